@@ rtl/tfn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, defaults and beat types of the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int COORD_W              = COORD_BITS_DEF;
    localparam int NORMAL_W             = NORMAL_FRAC_BITS_DEF + 2;

    localparam int RADICAND_W = 64;
    localparam int ROOT_W     = 32;
    localparam int NORM_MAG_W = 31;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic                       degenerate;
    } t_normal_out;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage
`default_nettype wire

@@ rtl/tfn_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside the radicand.
// ----------------------------------------------------------------------------
module tfn_isqrt
    import tfn_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_pipe_ctl             i_ctl,
    input  wire logic [RADICAND_W-1:0] i_radicand,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_valid,
    output logic [ROOT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int NSTG  = ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic                  r_v    [NSTG];
    logic [REM_W-1:0]      r_rem  [NSTG];
    logic [ROOT_W-1:0]     r_q    [NSTG];
    logic [RADICAND_W-1:0] r_s    [NSTG];
    logic [SIDE_W-1:0]     r_side [NSTG];

    for (genvar j = 0; j < NSTG; j++) begin : g_stg
        logic                  w_v;
        logic [REM_W-1:0]      w_rem;
        logic [ROOT_W-1:0]     w_q;
        logic [RADICAND_W-1:0] w_s;
        logic [SIDE_W-1:0]     w_side;
        logic [REM_W+1:0]      w_cur;
        logic [ROOT_W+1:0]     w_trial;
        logic [REM_W+1:0]      w_diff;

        if (j == 0) begin : g_first
            assign w_v    = i_ctl.valid;
            assign w_rem  = '0;
            assign w_q    = '0;
            assign w_s    = i_radicand;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_q    = r_q[j-1];
            assign w_s    = r_s[j-1];
            assign w_side = r_side[j-1];
        end

        assign w_cur   = {w_rem, w_s[RADICAND_W-1 -: 2]};
        assign w_trial = {w_q, 2'b01};
        assign w_diff  = w_cur - (REM_W+2)'(w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (w_cur >= (REM_W+2)'(w_trial)) begin
                    r_rem[j] <= w_diff[REM_W-1:0];
                    r_q[j]   <= {w_q[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[j] <= w_cur[REM_W-1:0];
                    r_q[j]   <= {w_q[ROOT_W-2:0], 1'b0};
                end
                r_s[j]    <= {w_s[RADICAND_W-3:0], 2'b00};
                r_side[j] <= w_side;
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_root  = r_q[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule
`default_nettype wire

@@ rtl/triangle_face_normal_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle: cross product of edges b-a and c-b, scaled to
// unit length in signed Q1.14.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries one triangle per beat as
// three Q12.12 vertices. Output channel o_out_valid / i_out_ready carries
// the normal and a degenerate flag, set with a zero normal when the cross
// product vanishes.
// Throughput is one triangle per cycle while the receiver does not stall.
// The pipeline has seven front stages (edges, products, cross,
// leading-one, shift, squares, sum), 32 root stages of the square root,
// one numerator stage, NORMAL_FRAC_BITS_DEF + 1 quotient stages of the
// restoring divider and the output register.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, o_in_ready drops and every stage holds its beat.
// Synchronous reset clears all stage valid bits; no result is shown until
// a new triangle has passed through.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit
    import tfn_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_tri_in     i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_normal_out      o_out_data
);

    localparam int CB    = COORD_BITS_DEF;
    localparam int NF    = NORMAL_FRAC_BITS_DEF;
    localparam int ESH   = (CB > 30) ? (CB - 30) : 0;
    localparam int EB    = CB + 1 - ESH;
    localparam int PW    = 2 * EB;
    localparam int MW    = PW + 1;
    localparam int POS_W = $clog2(MW);
    localparam int NW    = ROOT_W + NF;
    localparam int QW    = NF + 1;
    localparam int OW    = NF + 2;
    localparam int SIDE_W = 3 * NORM_MAG_W + 4;
    localparam int ND    = NF + 1;

    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // stage 1: edges
    logic signed [CB-1:0] w_p [9];
    logic [COORD_W-1:0]   w_f [9];

    assign w_f[0] = i_in_data.a_x;
    assign w_f[1] = i_in_data.a_y;
    assign w_f[2] = i_in_data.a_z;
    assign w_f[3] = i_in_data.b_x;
    assign w_f[4] = i_in_data.b_y;
    assign w_f[5] = i_in_data.b_z;
    assign w_f[6] = i_in_data.c_x;
    assign w_f[7] = i_in_data.c_y;
    assign w_f[8] = i_in_data.c_z;

    logic                 r_v1;
    logic signed [EB-1:0] r_e1 [3];
    logic signed [EB-1:0] r_e2 [3];

    for (genvar i = 0; i < 9; i++) begin : g_sext
        assign w_p[i] = CB'($signed(w_f[i]));
    end

    for (genvar i = 0; i < 3; i++) begin : g_edge
        logic signed [CB:0] w_d1;
        logic signed [CB:0] w_d2;
        logic signed [CB:0] w_s1;
        logic signed [CB:0] w_s2;
        assign w_d1 = (CB+1)'(w_p[3+i]) - (CB+1)'(w_p[i]);
        assign w_d2 = (CB+1)'(w_p[6+i]) - (CB+1)'(w_p[3+i]);
        assign w_s1 = w_d1 >>> ESH;
        assign w_s2 = w_d2 >>> ESH;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_e1[i] <= w_s1[EB-1:0];
                r_e2[i] <= w_s2[EB-1:0];
            end
        end
    end

    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_pr [6];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pr[0] <= PW'(r_e1[1]) * PW'(r_e2[2]);
            r_pr[1] <= PW'(r_e1[2]) * PW'(r_e2[1]);
            r_pr[2] <= PW'(r_e1[2]) * PW'(r_e2[0]);
            r_pr[3] <= PW'(r_e1[0]) * PW'(r_e2[2]);
            r_pr[4] <= PW'(r_e1[0]) * PW'(r_e2[1]);
            r_pr[5] <= PW'(r_e1[1]) * PW'(r_e2[0]);
        end
    end

    // stage 3: cross product, magnitude and sign
    logic          r_v3;
    logic [MW-1:0] r_mag [3];
    logic [2:0]    r_neg3;
    logic          r_deg3;
    logic signed [MW-1:0] w_cr [3];

    for (genvar i = 0; i < 3; i++) begin : g_cross
        assign w_cr[i] = MW'(r_pr[2*i]) - MW'(r_pr[2*i+1]);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_mag[i] <= w_cr[i][MW-1] ? MW'(-w_cr[i]) : MW'(w_cr[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_neg3[i] <= w_cr[i][MW-1];
            end
            r_deg3 <= (w_cr[0] == '0) && (w_cr[1] == '0) && (w_cr[2] == '0);
        end
    end

    // stage 4: leading one of the largest magnitude
    logic             r_v4;
    logic [MW-1:0]    r_mag4 [3];
    logic [POS_W-1:0] r_pos;
    logic [2:0]       r_neg4;
    logic             r_deg4;
    logic [MW-1:0]    w_or;
    logic [POS_W-1:0] w_pos;

    assign w_or = r_mag[0] | r_mag[1] | r_mag[2];

    always_comb begin
        w_pos = '0;
        for (int k = 0; k < MW; k++) begin
            if (w_or[k]) begin
                w_pos = POS_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag4 <= r_mag;
            r_pos  <= w_pos;
            r_neg4 <= r_neg3;
            r_deg4 <= r_deg3;
        end
    end

    // stage 5: scale so the largest magnitude lands in [2^30, 2^31)
    logic                  r_v5;
    logic [NORM_MAG_W-1:0] r_r5 [3];
    logic [2:0]            r_neg5;
    logic                  r_deg5;
    logic [POS_W:0]        w_rsh;

    assign w_rsh = {1'b0, r_pos} + (POS_W+1)'(1);

    for (genvar i = 0; i < 3; i++) begin : g_scale
        logic [MW+NORM_MAG_W-1:0] w_ext;
        logic [MW+NORM_MAG_W-1:0] w_sh;
        assign w_ext = {r_mag4[i], {NORM_MAG_W{1'b0}}};
        assign w_sh  = w_ext >> w_rsh;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_r5[i] <= w_sh[NORM_MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg5 <= r_neg4;
            r_deg5 <= r_deg4;
        end
    end

    // stage 6: squares
    logic                    r_v6;
    logic [NORM_MAG_W-1:0]   r_r6 [3];
    logic [2*NORM_MAG_W-1:0] r_sq [3];
    logic [2:0]              r_neg6;
    logic                    r_deg6;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*NORM_MAG_W)'(r_r5[i]) * (2*NORM_MAG_W)'(r_r5[i]);
            end
            r_r6   <= r_r5;
            r_neg6 <= r_neg5;
            r_deg6 <= r_deg5;
        end
    end

    // stage 7: sum of squares
    logic                  r_v7;
    logic [RADICAND_W-1:0] r_sum;
    logic [SIDE_W-1:0]     r_side7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum   <= RADICAND_W'(r_sq[0]) + RADICAND_W'(r_sq[1])
                     + RADICAND_W'(r_sq[2]);
            r_side7 <= {r_r6[0], r_r6[1], r_r6[2], r_neg6, r_deg6};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // length
    t_pipe_ctl         w_sq_ctl;
    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_len;
    logic [SIDE_W-1:0] w_sq_side;

    assign w_sq_ctl.en    = w_en;
    assign w_sq_ctl.valid = r_v7;

    tfn_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_sq_ctl),
        .i_radicand (r_sum),
        .i_side     (r_side7),
        .o_valid    (w_sq_valid),
        .o_root     (w_len),
        .o_side     (w_sq_side)
    );

    // numerator stage
    logic [NORM_MAG_W-1:0] w_rr [3];
    assign w_rr[0] = w_sq_side[SIDE_W-1 -: NORM_MAG_W];
    assign w_rr[1] = w_sq_side[SIDE_W-1-NORM_MAG_W -: NORM_MAG_W];
    assign w_rr[2] = w_sq_side[SIDE_W-1-2*NORM_MAG_W -: NORM_MAG_W];

    logic              r_vn;
    logic [NW-1:0]     r_num [3];
    logic [ROOT_W-1:0] r_lenn;
    logic [2:0]        r_negn;
    logic              r_degn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 1'b0;
        end else if (w_en) begin
            r_vn <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {1'b0, w_rr[i], {NF{1'b0}}}
                          + NW'(w_len[ROOT_W-1:1]);
            end
            r_lenn <= w_len;
            r_negn <= w_sq_side[3:1];
            r_degn <= w_sq_side[0];
        end
    end

    // restoring divide, one quotient bit per stage
    logic              r_vd   [ND];
    logic [NW-1:0]     r_rem  [ND][3];
    logic [QW-1:0]     r_q    [ND][3];
    logic [ROOT_W-1:0] r_lend [ND];
    logic [2:0]        r_negd [ND];
    logic              r_degd [ND];

    for (genvar j = 0; j < ND; j++) begin : g_div
        localparam int K = NF - j;
        logic              w_v;
        logic [NW-1:0]     w_rem [3];
        logic [QW-1:0]     w_q   [3];
        logic [ROOT_W-1:0] w_len_in;
        logic [2:0]        w_neg;
        logic              w_deg;
        logic [NW-1:0]     w_dvs;

        if (j == 0) begin : g_first
            assign w_v      = r_vn;
            assign w_rem    = r_num;
            assign w_len_in = r_lenn;
            assign w_neg    = r_negn;
            assign w_deg    = r_degn;
            for (genvar i = 0; i < 3; i++) begin : g_q0
                assign w_q[i] = '0;
            end
        end else begin : g_next
            assign w_v      = r_vd[j-1];
            assign w_rem    = r_rem[j-1];
            assign w_q      = r_q[j-1];
            assign w_len_in = r_lend[j-1];
            assign w_neg    = r_negd[j-1];
            assign w_deg    = r_degd[j-1];
        end

        assign w_dvs = NW'(w_len_in) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[j] <= 1'b0;
            end else if (w_en) begin
                r_vd[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_rem[i] >= w_dvs) begin
                        r_rem[j][i] <= w_rem[i] - w_dvs;
                        r_q[j][i]   <= w_q[i] | (QW'(1) << K);
                    end else begin
                        r_rem[j][i] <= w_rem[i];
                        r_q[j][i]   <= w_q[i];
                    end
                end
                r_lend[j] <= w_len_in;
                r_negd[j] <= w_neg;
                r_degd[j] <= w_deg;
            end
        end
    end

    // output register
    logic signed [OW-1:0] w_comp [3];

    for (genvar i = 0; i < 3; i++) begin : g_sign
        logic signed [OW-1:0] w_mag;
        assign w_mag     = OW'(r_q[ND-1][i]);
        assign w_comp[i] = r_degd[ND-1] ? '0 : (r_negd[ND-1][i] ? -w_mag : w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= r_vd[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_data.normal_x   <= NORMAL_W'(w_comp[0]);
            o_out_data.normal_y   <= NORMAL_W'(w_comp[1]);
            o_out_data.normal_z   <= NORMAL_W'(w_comp[2]);
            o_out_data.degenerate <= r_degd[ND-1];
        end
    end

endmodule
`default_nettype wire

@@ rtl/tfn_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks of the triangle face normal unit, bound to its top.
// ----------------------------------------------------------------------------
module tfn_checker
    import tfn_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_normal_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.normal_x == '0 && o_out_data.normal_y == '0 &&
            o_out_data.normal_z == '0)
        else $error("degenerate beat with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.normal_x >= -16'sd16384 && o_out_data.normal_x <= 16'sd16384 &&
            o_out_data.normal_y >= -16'sd16384 && o_out_data.normal_y <= 16'sd16384 &&
            o_out_data.normal_z >= -16'sd16384 && o_out_data.normal_z <= 16'sd16384)
        else $error("normal component out of unit range");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (.*);
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the triangle face normal unit: directed triangles (axis-aligned,
// extreme coordinates, degenerate faces) and a long random stream, each result
// compared with an in-bench fixed-point normal computation, under random
// stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import tfn_pkg::*;

    localparam int LATENCY = 42 + NORMAL_FRAC_BITS_DEF;
    localparam int N_RANDOM = 1800;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_tri_in     i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_normal_out o_out_data;

    t_normal_out normal_q[$];
    int          n_fail;
    bit          src_done;
    bit          hold_long;

    triangle_face_normal_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sqrt_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_normal_out face_normal(t_tri_in t);
        t_normal_out r;
        logic signed [63:0] e1[3], e2[3], cr[3];
        logic [63:0] mag[3], mx, s, len, q;
        e1[0] = 64'(t.b_x) - 64'(t.a_x);
        e1[1] = 64'(t.b_y) - 64'(t.a_y);
        e1[2] = 64'(t.b_z) - 64'(t.a_z);
        e2[0] = 64'(t.c_x) - 64'(t.b_x);
        e2[1] = 64'(t.c_y) - 64'(t.b_y);
        e2[2] = 64'(t.c_z) - 64'(t.b_z);
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '0;
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (mag[i] > mx) mx = mag[i];
        end
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        s = 0;
        for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
        len = sqrt_floor(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << NORMAL_FRAC_BITS_DEF) + (len >> 1)) / len;
            if (cr[i] < 0) q = -q;
            case (i)
                0: r.normal_x = q[NORMAL_W-1:0];
                1: r.normal_y = q[NORMAL_W-1:0];
                default: r.normal_z = q[NORMAL_W-1:0];
            endcase
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            2: return COORD_W'($signed($urandom_range(0, 64)) - 32);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_tri_in rand_tri();
        t_tri_in t;
        t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
        if ($urandom_range(0, 9) == 0) t.c_x = t.b_x;
        if ($urandom_range(0, 19) == 0) t = {3{t.a_x, t.a_y, t.a_z}};
        return t;
    endfunction

    task automatic send_beat(t_tri_in t);
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        normal_q.push_back(face_normal(t));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Directed table: expected normal given where it is obvious, else predicted
    localparam logic [COORD_W-1:0] ONE  = 24'h001000;
    localparam logic [COORD_W-1:0] MAXC = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] MINC = 24'h800000;
    localparam int N_DIR = 10;
    t_tri_in     dir_tri[N_DIR];
    t_normal_out dir_exp[N_DIR];
    bit          dir_has[N_DIR];

    initial begin
        dir_tri[0] = {9{24'h0}};
        dir_exp[0] = '{0, 0, 0, 1'b1}; dir_has[0] = 1;
        dir_tri[1] = {24'h0, 24'h0, 24'h0, ONE, 24'h0, 24'h0, ONE, ONE, 24'h0};
        dir_exp[1] = '{0, 0, 16'sd16384, 1'b0}; dir_has[1] = 1;
        dir_tri[2] = {24'h0, 24'h0, 24'h0, 24'h0, ONE, 24'h0, 24'h0, ONE, ONE};
        dir_exp[2] = '{16'sd16384, 0, 0, 1'b0}; dir_has[2] = 1;
        dir_tri[3] = {24'h0, 24'h0, 24'h0, 24'h0, 24'h0, ONE, ONE, 24'h0, ONE};
        dir_exp[3] = '{0, 16'sd16384, 0, 1'b0}; dir_has[3] = 1;
        dir_tri[4] = {24'h0, 24'h0, 24'h0, 24'h0, ONE, 24'h0, ONE, ONE, 24'h0};
        dir_exp[4] = '{0, 0, -16'sd16384, 1'b0}; dir_has[4] = 1;
        dir_tri[5] = {MINC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MINC};
        dir_has[5] = 0;
        dir_tri[6] = {MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC};
        dir_has[6] = 0;
        dir_tri[7] = {ONE, ONE, ONE, 24'h2000, 24'h2000, 24'h2000, MAXC, MAXC, MAXC};
        dir_exp[7] = '{0, 0, 0, 1'b1}; dir_has[7] = 1;
        dir_tri[8] = {MINC, MAXC, 24'h1, MAXC, MINC, 24'hFFFFFF, 24'h1, 24'h0, MAXC};
        dir_has[8] = 0;
        dir_tri[9] = {24'h0, 24'h0, 24'h0, 24'h1, 24'h0, 24'h0, 24'h1, 24'h1, 24'h0};
        dir_exp[9] = '{0, 0, 16'sd16384, 1'b0}; dir_has[9] = 1;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        n_fail      = 0;
        src_done    = 0;
        hold_long   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < N_DIR; k++) begin
            send_beat(dir_tri[k]);
            if (dir_has[k] && normal_q[$] !== dir_exp[k]) begin
                $error("table row %0d disagrees with predictor", k);
                n_fail++;
            end
        end
        i_in_valid <= 1'b0;
        // drain fully before the random stream
        while (normal_q.size() != 0) @(posedge i_clk);
        for (int k = 0; k < N_RANDOM; k++) begin
            int g;
            g = gap_len();
            if (g != 0) begin
                i_in_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            if (k == N_RANDOM / 3) hold_long = 1;
            if (k == 2 * N_RANDOM / 3) begin
                i_in_valid <= 1'b0;
                while (normal_q.size() != 0) @(posedge i_clk);
            end
            send_beat(rand_tri());
        end
        i_in_valid <= 1'b0;
        src_done = 1;
    end

    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                hold_long = 0;
                i_out_ready <= 1'b0;
                repeat (3 * LATENCY) @(posedge i_clk);
            end
            if ($urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_normal_out e;
            if (normal_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_fail++;
            end else begin
                e = normal_q.pop_front();
                if (o_out_data.normal_x !== e.normal_x) begin
                    $error("normal_x exp %0d got %0d", e.normal_x, o_out_data.normal_x);
                    n_fail++;
                end
                if (o_out_data.normal_y !== e.normal_y) begin
                    $error("normal_y exp %0d got %0d", e.normal_y, o_out_data.normal_y);
                    n_fail++;
                end
                if (o_out_data.normal_z !== e.normal_z) begin
                    $error("normal_z exp %0d got %0d", e.normal_z, o_out_data.normal_z);
                    n_fail++;
                end
                if (o_out_data.degenerate !== e.degenerate) begin
                    $error("degenerate exp %0b got %0b", e.degenerate,
                           o_out_data.degenerate);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        wait (src_done);
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (n_fail == 0 && normal_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tfn_pkg.sv
rtl/tfn_isqrt.sv
rtl/triangle_face_normal_unit.sv
rtl/tfn_checker.sv
verif/tb_top.sv
